[hw/rtl/nm16_pkg.sv]
// ----------------------------------------------------------------------------
// nm16_pkg - shared types and nim arithmetic for the 16-bit nim multiplier
// Small fixed-width nim products used by the pipeline stages.
// ----------------------------------------------------------------------------
package nm16_pkg;

	localparam int OperandBits = 16;
	localparam int LaneCount   = 9;

	typedef logic [3:0] nib_t;
	typedef logic [7:0] byte_t;

	typedef struct packed {
		nib_t a;
		nib_t b;
	} pair4_t;

	typedef pair4_t [LaneCount-1:0] pair4_vec_t;
	typedef nib_t   [LaneCount-1:0] prod4_vec_t;
	typedef byte_t  [2:0]           prod8_vec_t;

	// Nim product in the field of 4 elements.
	function automatic logic [1:0] nim2(input logic [1:0] x, input logic [1:0] y);
		logic p00;
		logic pm;
		logic p11;
		p00 = x[0] & y[0];
		pm  = (x[0] ^ x[1]) & (y[0] ^ y[1]);
		p11 = x[1] & y[1];
		return {pm ^ p00, p00 ^ p11};
	endfunction

	// Nim product in the field of 16 elements.
	function automatic nib_t nim4(input nib_t x, input nib_t y);
		logic [1:0] p00;
		logic [1:0] pm;
		logic [1:0] p11;
		p00 = nim2(x[1:0], y[1:0]);
		pm  = nim2(x[1:0] ^ x[3:2], y[1:0] ^ y[3:2]);
		p11 = nim2(x[3:2], y[3:2]);
		return {pm ^ p00, p00 ^ nim2(p11, 2'b10)};
	endfunction

	// Nim product in the field of 256 elements.
	function automatic byte_t nim8(input byte_t x, input byte_t y);
		nib_t p00;
		nib_t pm;
		nib_t p11;
		p00 = nim4(x[3:0], y[3:0]);
		pm  = nim4(x[3:0] ^ x[7:4], y[3:0] ^ y[7:4]);
		p11 = nim4(x[7:4], y[7:4]);
		return {pm ^ p00, p00 ^ nim4(p11, 4'h8)};
	endfunction

endpackage

[hw/rtl/nimber_multiply_16.sv]
// ----------------------------------------------------------------------------
// nimber_multiply_16 - pipelined 16-bit nim multiplier
// Nim product of two 16-bit nimbers, one operand pair per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Drive left_operand/right_operand and raise start; the word is taken at
//   the rising edge where start is high and busy is low. busy is always low,
//   so a new word may be issued every cycle.
//   The product appears on product with done high for exactly one cycle,
//   once the word has passed the split, 4-bit product, 8-bit merge and
//   16-bit merge stages (one register stage each). Throughput is one
//   product per cycle; results come out in issue order.
//   Operands are masked to FIELD_BITS bits (capped at 16) before use.
//   The receiver cannot stall; done must be sampled when it is high.
//   arst_n clears all stage valid bits; words in flight are dropped and no
//   done is raised until new words have passed the four stages.
// ----------------------------------------------------------------------------
module nimber_multiply_16 #(
	parameter int FIELD_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [nm16_pkg::OperandBits-1:0] left_operand,
	input  logic [nm16_pkg::OperandBits-1:0] right_operand,
	output logic                             done,
	output logic [nm16_pkg::OperandBits-1:0] product
);
	import nm16_pkg::*;

	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	pair4_vec_t pairs_s1;
	prod4_vec_t prods_s2;
	prod8_vec_t prods_s3;

	assign busy = 1'b0;

	nm16_split_stage #(
		.FIELD_BITS(FIELD_BITS)
	) u_split (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.left_operand (left_operand),
		.right_operand(right_operand),
		.valid_s1     (valid_s1),
		.pairs_s1     (pairs_s1)
	);

	nm16_prod_stage u_prod (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.pairs_s1(pairs_s1),
		.valid_s2(valid_s2),
		.prods_s2(prods_s2)
	);

	nm16_merge8_stage u_merge8 (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s2(valid_s2),
		.prods_s2(prods_s2),
		.valid_s3(valid_s3),
		.prods_s3(prods_s3)
	);

	nm16_merge16_stage u_merge16 (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.prods_s3  (prods_s3),
		.valid_s4  (done),
		.product_s4(product)
	);

endmodule

[hw/rtl/nm16_split_stage.sv]
// ----------------------------------------------------------------------------
// nm16_split_stage - operand masking and two-level Karatsuba split
// Breaks each operand pair into nine 4-bit sub-pairs and registers them.
// ----------------------------------------------------------------------------
module nm16_split_stage #(
	parameter int FIELD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [nm16_pkg::OperandBits-1:0] left_operand,
	input  logic [nm16_pkg::OperandBits-1:0] right_operand,
	output logic                            valid_s1,
	output nm16_pkg::pair4_vec_t            pairs_s1
);
	import nm16_pkg::*;

	localparam int MaskBits = (FIELD_BITS > OperandBits) ? OperandBits :
		((FIELD_BITS < 1) ? 1 : FIELD_BITS);
	localparam logic [31:0] MaskWide = (32'd1 << MaskBits) - 32'd1;
	localparam logic [OperandBits-1:0] OpMask = MaskWide[OperandBits-1:0];

	logic [OperandBits-1:0] a;
	logic [OperandBits-1:0] b;
	byte_t [2:0] a8;
	byte_t [2:0] b8;
	pair4_vec_t pairs;

	always_comb begin
		a = left_operand & OpMask;
		b = right_operand & OpMask;
		// lane order per level: low halves, xor of halves, high halves
		a8[0] = a[7:0];
		a8[1] = a[7:0] ^ a[15:8];
		a8[2] = a[15:8];
		b8[0] = b[7:0];
		b8[1] = b[7:0] ^ b[15:8];
		b8[2] = b[15:8];
		for (int g = 0; g < 3; g++) begin
			pairs[3*g+0].a = a8[g][3:0];
			pairs[3*g+0].b = b8[g][3:0];
			pairs[3*g+1].a = a8[g][3:0] ^ a8[g][7:4];
			pairs[3*g+1].b = b8[g][3:0] ^ b8[g][7:4];
			pairs[3*g+2].a = a8[g][7:4];
			pairs[3*g+2].b = b8[g][7:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pairs_s1 <= pairs;
	end

endmodule

[hw/rtl/nm16_prod_stage.sv]
// ----------------------------------------------------------------------------
// nm16_prod_stage - nine parallel 4-bit nim products
// One small product per sub-pair, registered.
// ----------------------------------------------------------------------------
module nm16_prod_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  nm16_pkg::pair4_vec_t pairs_s1,
	output logic                 valid_s2,
	output nm16_pkg::prod4_vec_t prods_s2
);
	import nm16_pkg::*;

	prod4_vec_t prods;

	always_comb begin
		for (int i = 0; i < LaneCount; i++) begin
			prods[i] = nim4(pairs_s1[i].a, pairs_s1[i].b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prods_s2 <= prods;
	end

endmodule

[hw/rtl/nm16_merge8_stage.sv]
// ----------------------------------------------------------------------------
// nm16_merge8_stage - recombine 4-bit products into three 8-bit products
// hi = mid ^ low, lo = low ^ high * 8 in the 16-element field.
// ----------------------------------------------------------------------------
module nm16_merge8_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s2,
	input  nm16_pkg::prod4_vec_t prods_s2,
	output logic                 valid_s3,
	output nm16_pkg::prod8_vec_t prods_s3
);
	import nm16_pkg::*;

	prod8_vec_t prods;

	always_comb begin
		for (int g = 0; g < 3; g++) begin
			prods[g] = {prods_s2[3*g+1] ^ prods_s2[3*g+0],
				prods_s2[3*g+0] ^ nim4(prods_s2[3*g+2], 4'h8)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		prods_s3 <= prods;
	end

endmodule

[hw/rtl/nm16_merge16_stage.sv]
// ----------------------------------------------------------------------------
// nm16_merge16_stage - final recombination into the 16-bit product
// hi = mid ^ low, lo = low ^ high * 0x80 in the 256-element field.
// ----------------------------------------------------------------------------
module nm16_merge16_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s3,
	input  nm16_pkg::prod8_vec_t             prods_s3,
	output logic                             valid_s4,
	output logic [nm16_pkg::OperandBits-1:0] product_s4
);
	import nm16_pkg::*;

	logic [OperandBits-1:0] prod;

	assign prod = {prods_s3[1] ^ prods_s3[0], prods_s3[0] ^ nim8(prods_s3[2], 8'h80)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		product_s4 <= prod;
	end

endmodule

[hw/rtl/nm16_checker.sv]
// ----------------------------------------------------------------------------
// nm16_checker - port-level assertions for nimber_multiply_16
// Checks busy staying low, latency, ordering of strobes and the zero-operand product.
// ----------------------------------------------------------------------------
module nm16_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic [nm16_pkg::OperandBits-1:0] left_operand,
	input logic [nm16_pkg::OperandBits-1:0] right_operand,
	input logic                             done,
	input logic [nm16_pkg::OperandBits-1:0] product
);
	import nm16_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("done without a word taken four cycles earlier");

	a_word_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("word taken but no done four cycles later");

	a_zero_operand: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(left_operand, 4) == '0 || $past(right_operand, 4) == '0))
		|-> product == '0)
		else $error("nonzero product for a zero operand");

endmodule

bind nimber_multiply_16 nm16_checker u_nm16_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.left_operand (left_operand),
	.right_operand(right_operand),
	.done         (done),
	.product      (product)
);
